// File: src/nda_pkg.sv
// shared constants and control types for the nucleotide diversity accumulator
package nda_pkg;

    localparam int CNT_W      = 10;
    localparam int NUM_CNT    = 6;
    localparam int STEP_W     = 3;
    localparam int MUL_STEPS  = 7;
    localparam int PROD_W     = 2 * CNT_W;
    localparam int S_W        = PROD_W + 3;
    localparam int FRAC_BITS  = 24;
    localparam int TERM_W     = FRAC_BITS + 1;
    localparam int SUM_W      = 41;
    localparam int CNT_CTR_W  = 5;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 48;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BINARY_MODE = 1'b1;

    typedef struct packed {
        logic              load;
        logic              mul;
        logic [STEP_W-1:0] step;
        logic              prep;
        logic              div;
        logic              acc;
    } nda_cmd_t;

    typedef struct packed {
        logic last;
        logic out_busy;
    } nda_status_t;

endpackage

// File: src/nucleotide_diversity_accumulator.sv
// Nucleotide diversity accumulator. Each accepted site runs these steps until s_tready
// returns: an accept step, 7 passes through one shared 10x10 multiplier (in nucleotide mode
// six count products and the denominator), a setup step, a restoring divider that produces
// one fraction bit per cycle, and an accumulate step. The per-site term is floored to 24
// fraction bits and added into a 41-bit saturating sum. On a site marked by s_tlast the
// total and saturation flag go to an output register and the sum is cleared; the accumulate
// step of a last site waits only while a previous total is still not taken. Configuration
// writes are always accepted and must be issued while the block is idle.
module nucleotide_diversity_accumulator
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // count_a, count_g, count_c, count_t, count_zero, count_one, count_missing, zero pad
    input  logic [nda_pkg::IN_DATA_W-1:0]        s_tdata,
    // has_gap
    input  logic                                 s_tuser,
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // pi_total, zero pad
    output logic [nda_pkg::OUT_DATA_W-1:0]       m_tdata,
    // saturated
    output logic                                 m_tuser,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [nda_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [nda_pkg::CNT_W-1:0]            cfg_data
);

    nda_pkg::nda_cmd_t            cmd;
    nda_pkg::nda_status_t         status;
    logic [nda_pkg::CNT_W-1:0]    in_cnt [nda_pkg::NUM_CNT];
    logic [nda_pkg::CNT_W-1:0]    in_missing;
    logic [nda_pkg::SUM_W-1:0]    out_sum;

    always_comb
    begin
        for (int k = 0; k < nda_pkg::NUM_CNT; k++)
        begin
            in_cnt[k] = s_tdata[k*nda_pkg::CNT_W +: nda_pkg::CNT_W];
        end
    end

    assign in_missing = s_tdata[nda_pkg::NUM_CNT*nda_pkg::CNT_W +: nda_pkg::CNT_W];
    assign cfg_ready  = 1'b1;
    assign m_tdata    = {{(nda_pkg::OUT_DATA_W - nda_pkg::SUM_W){1'b0}}, out_sum};

    nda_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    nda_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .in_cnt     (in_cnt),
        .in_missing (in_missing),
        .in_gap     (s_tuser),
        .in_last    (s_tlast),
        .cfg_we     (cfg_valid),
        .cfg_idx    (cfg_index),
        .cfg_value  (cfg_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_sum    (out_sum),
        .out_flag   (m_tuser)
    );

endmodule

// File: src/nda_ctrl.sv
// sequencer: shared multiplier steps, division steps, accumulate
module nda_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  nda_pkg::nda_status_t status,
    output nda_pkg::nda_cmd_t    cmd
);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_MUL,
        ST_PREP,
        ST_DIV,
        ST_ACC
    } state_t;

    state_t                            state_reg;
    logic [nda_pkg::CNT_CTR_W-1:0]     cnt_reg;

    localparam logic [nda_pkg::CNT_CTR_W-1:0] MUL_LAST =
        nda_pkg::CNT_CTR_W'(nda_pkg::MUL_STEPS - 1);
    localparam logic [nda_pkg::CNT_CTR_W-1:0] DIV_LAST =
        nda_pkg::CNT_CTR_W'(nda_pkg::FRAC_BITS - 1);

    logic acc_go;

    assign acc_go   = (state_reg == ST_ACC) && !(status.last && status.out_busy);
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd      = '0;
        cmd.load = (state_reg == ST_IDLE) && in_valid;
        cmd.mul  = (state_reg == ST_MUL);
        cmd.step = cnt_reg[nda_pkg::STEP_W-1:0];
        cmd.prep = (state_reg == ST_PREP);
        cmd.div  = (state_reg == ST_DIV);
        cmd.acc  = acc_go;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    if (in_valid)
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    if (cnt_reg == MUL_LAST)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_PREP;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_PREP:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (cnt_reg == DIV_LAST)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_ACC;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_ACC:
                begin
                    if (acc_go)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: src/nda_datapath.sv
// datapath: config registers, shared multiplier, restoring divider, saturating sum
module nda_datapath
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  nda_pkg::nda_cmd_t                    cmd,
    output nda_pkg::nda_status_t                 status,
    input  logic [nda_pkg::CNT_W-1:0]            in_cnt [nda_pkg::NUM_CNT],
    input  logic [nda_pkg::CNT_W-1:0]            in_missing,
    input  logic                                 in_gap,
    input  logic                                 in_last,
    input  logic                                 cfg_we,
    input  logic [nda_pkg::CFG_IDX_W-1:0]        cfg_idx,
    input  logic [nda_pkg::CNT_W-1:0]            cfg_value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [nda_pkg::SUM_W-1:0]            out_sum,
    output logic                                 out_flag
);

    localparam logic [nda_pkg::SUM_W-1:0] SUM_MAX = '1;

    // configuration
    logic [nda_pkg::CNT_W-1:0]      n_reg;
    logic                           bin_reg;

    // item
    logic [nda_pkg::CNT_W-1:0]      cnt_reg [nda_pkg::NUM_CNT];
    logic [nda_pkg::CNT_W-1:0]      miss_reg;
    logic                           gap_reg;
    logic                           last_reg;

    // working values
    logic [2:0]                     states_reg;
    logic [nda_pkg::S_W-1:0]        s_reg;
    logic [nda_pkg::PROD_W-1:0]     d_reg;
    logic                           zero_reg;
    logic                           qint_reg;
    logic [nda_pkg::FRAC_BITS-1:0]  qfrac_reg;
    logic [nda_pkg::PROD_W-1:0]     rem_reg;

    // accumulator and output
    logic [nda_pkg::SUM_W-1:0]      sum_reg;
    logic                           flag_reg;
    logic                           out_valid_reg;
    logic [nda_pkg::SUM_W-1:0]      out_sum_reg;
    logic                           out_flag_reg;

    logic [nda_pkg::CNT_W-1:0]      m_val;
    logic                           miss_gt;
    logic [nda_pkg::CNT_W-1:0]      mul_x;
    logic [nda_pkg::CNT_W-1:0]      mul_y;
    logic [nda_pkg::PROD_W-1:0]     product;
    logic [nda_pkg::PROD_W-1:0]     num2;
    logic                           nuc_skip;
    logic                           bin_skip;
    logic                           skip;
    logic [nda_pkg::PROD_W-1:0]     num;
    logic [nda_pkg::PROD_W:0]       trial;
    logic                           ge;
    logic [nda_pkg::TERM_W-1:0]     term;
    logic [nda_pkg::SUM_W:0]        wide;
    logic [nda_pkg::SUM_W-1:0]      sum_next;
    logic                           flag_next;

    assign m_val   = n_reg - miss_reg;
    assign miss_gt = miss_reg > n_reg;

    // operand select for the one shared multiplier
    always_comb
    begin
        mul_x = '0;
        mul_y = '0;
        if (bin_reg)
        begin
            if (cmd.step == 3'd0)
            begin
                mul_x = cnt_reg[nda_pkg::NUM_CNT-1];
                mul_y = n_reg - cnt_reg[nda_pkg::NUM_CNT-1];
            end
            else if (cmd.step == 3'd1)
            begin
                mul_x = n_reg;
                mul_y = n_reg - 1'b1;
            end
        end
        else if (cmd.step < nda_pkg::STEP_W'(nda_pkg::NUM_CNT))
        begin
            mul_x = cnt_reg[cmd.step];
            mul_y = cnt_reg[cmd.step] - 1'b1;
        end
        else
        begin
            mul_x = m_val;
            mul_y = m_val - 1'b1;
        end
    end

    assign product = mul_x * mul_y;

    // in binary mode s_reg holds one*(n-one), which stays below 2^18 while one is at most n
    assign num2     = {s_reg[nda_pkg::PROD_W-2:0], 1'b0};
    assign nuc_skip = gap_reg || (states_reg < 3'd2) || miss_gt || (m_val < 10'd2) ||
                      (s_reg > {3'b000, d_reg});
    assign bin_skip = (n_reg < 10'd2) || (cnt_reg[nda_pkg::NUM_CNT-1] > n_reg) ||
                      (num2 > d_reg);
    assign skip     = bin_reg ? bin_skip : nuc_skip;
    assign num      = bin_reg ? num2 : (d_reg - s_reg[nda_pkg::PROD_W-1:0]);

    assign trial = {rem_reg, 1'b0};
    assign ge    = trial >= {1'b0, d_reg};

    assign term = zero_reg ? '0 : {qint_reg, qfrac_reg};
    assign wide = {1'b0, sum_reg} + (nda_pkg::SUM_W + 1)'(term);

    always_comb
    begin
        if (wide > {1'b0, SUM_MAX})
        begin
            sum_next  = SUM_MAX;
            flag_next = 1'b1;
        end
        else
        begin
            sum_next  = wide[nda_pkg::SUM_W-1:0];
            flag_next = flag_reg || (wide[nda_pkg::SUM_W-1:0] == SUM_MAX);
        end
    end

    assign status.last     = last_reg;
    assign status.out_busy = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_sum   = out_sum_reg;
    assign out_flag  = out_flag_reg;

    // config registers, accumulator and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= '0;
            bin_reg       <= 1'b0;
            sum_reg       <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    nda_pkg::REG_SAMPLE_SIZE: n_reg   <= cfg_value;
                    nda_pkg::REG_BINARY_MODE: bin_reg <= cfg_value[0];
                    default:                  n_reg   <= n_reg;
                endcase
            end
            // a new total may load in the same cycle the previous one is taken
            if (cmd.acc && last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.acc)
            begin
                if (last_reg)
                begin
                    sum_reg  <= '0;
                    flag_reg <= 1'b0;
                end
                else
                begin
                    sum_reg  <= sum_next;
                    flag_reg <= flag_next;
                end
            end
        end
    end

    // item payload and per-item working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cnt_reg    <= in_cnt;
            miss_reg   <= in_missing;
            gap_reg    <= in_gap;
            last_reg   <= in_last;
            states_reg <= '0;
            s_reg      <= '0;
        end
        if (cmd.mul)
        begin
            if (bin_reg)
            begin
                if (cmd.step == 3'd0)
                begin
                    s_reg <= nda_pkg::S_W'(product);
                end
                else if (cmd.step == 3'd1)
                begin
                    d_reg <= product;
                end
            end
            else if (cmd.step < nda_pkg::STEP_W'(nda_pkg::NUM_CNT))
            begin
                s_reg <= s_reg + nda_pkg::S_W'(product);
                if (cnt_reg[cmd.step] != '0)
                begin
                    states_reg <= states_reg + 1'b1;
                end
            end
            else
            begin
                d_reg <= product;
            end
        end
        if (cmd.prep)
        begin
            zero_reg  <= skip;
            qint_reg  <= (num == d_reg);
            rem_reg   <= (num == d_reg) ? '0 : num;
            qfrac_reg <= '0;
        end
        if (cmd.div)
        begin
            rem_reg   <= ge ? nda_pkg::PROD_W'(trial - {1'b0, d_reg})
                            : trial[nda_pkg::PROD_W-1:0];
            qfrac_reg <= {qfrac_reg[nda_pkg::FRAC_BITS-2:0], ge};
        end
        if (cmd.acc && last_reg)
        begin
            out_sum_reg  <= sum_next;
            out_flag_reg <= flag_next;
        end
    end

endmodule

// File: src/nda_checker.sv
// port-level checks for the nucleotide diversity accumulator
module nda_port_checks
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [nda_pkg::OUT_DATA_W-1:0]    m_tdata,
    input logic                              m_tuser
);

    // a site keeps the block busy, with s_tready low, after its transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready ##1 !s_tready ##1 !s_tready)
        else $error("input ready too soon after a transaction");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[nda_pkg::OUT_DATA_W-1:nda_pkg::SUM_W] == '0))
        else $error("result padding not zero");

    // the sum only grows until cleared, so a saturated total sits at full scale
    a_sat_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[nda_pkg::SUM_W-1:0] == '1))
        else $error("saturated total below full scale");

    // a new total does not appear straight after a site is taken
    a_out_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
        else $error("result appeared right after a site transaction");

endmodule

bind nucleotide_diversity_accumulator nda_port_checks u_nda_port_checks (.*);

// File: sim/nda_checker.sv
// checker for the nucleotide diversity accumulator: mirrors the site sums and compares totals
module nda_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [nda_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic                               s_tuser,
    input  logic                               s_tlast,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [nda_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                               m_tuser,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [nda_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [nda_pkg::CNT_W-1:0]          cfg_data,
    output int                                 pending,
    output int                                 errors
);
    timeunit 1ns;
    timeprecision 1ps;
    import nda_pkg::*;

    localparam longint unsigned SUM_MAX = (64'd1 << SUM_W) - 64'd1;
    localparam int ONE_POS = 5 * CNT_W;

    typedef struct packed {
        logic [SUM_W-1:0] total;
        logic             sat;
    } total_t;

    total_t            due_totals [$];
    total_t            head;
    total_t            nxt;
    longint unsigned   run_sum;
    logic              run_sat;
    logic [CNT_W-1:0]  n_samples;
    logic              bin_mode;
    longint unsigned   term;
    int                err_cnt = 0;

    function automatic longint unsigned scaled_share(input longint unsigned num,
                                                     input longint unsigned den);
        if (den == 0 || num > den)
            return 0;
        return (num << FRAC_BITS) / den;
    endfunction

    // heterozygosity of one site, floored to the fraction width
    function automatic longint unsigned site_share(input logic [NUM_CNT*CNT_W-1:0] counts,
                                                   input logic [CNT_W-1:0] missing,
                                                   input logic gap);
        longint unsigned n;
        longint unsigned c;
        longint unsigned ones;
        longint unsigned homo;
        longint unsigned m;
        longint unsigned d;
        int              k;
        int              present;
        n = n_samples;
        if (bin_mode)
        begin
            ones = counts[ONE_POS +: CNT_W];
            if (n < 2 || ones > n)
                return 0;
            return scaled_share(2 * ones * (n - ones), n * (n - 1));
        end
        if (gap)
            return 0;
        homo = 0;
        present = 0;
        for (k = 0; k < NUM_CNT; k++)
        begin
            c = counts[k*CNT_W +: CNT_W];
            if (c != 0)
            begin
                present++;
                homo += c * (c - 1);
            end
        end
        if (present < 2 || missing > n)
            return 0;
        m = n - missing;
        if (m < 2)
            return 0;
        d = m * (m - 1);
        if (homo > d)
            return 0;
        return scaled_share(d - homo, d);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_sum = 0;
            run_sat = 1'b0;
            n_samples = '0;
            bin_mode = 1'b0;
            due_totals.delete();
            pending <= 0;
            errors <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (due_totals.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: unexpected total, expected none, got pi_total %0d saturated %0b",
                             $time, m_tdata[SUM_W-1:0], m_tuser);
                end
                else
                begin
                    head = due_totals.pop_front();
                    if (m_tdata[SUM_W-1:0] !== head.total)
                    begin
                        err_cnt++;
                        $display("%0t: pi_total expected %0d got %0d",
                                 $time, head.total, m_tdata[SUM_W-1:0]);
                    end
                    if (m_tuser !== head.sat)
                    begin
                        err_cnt++;
                        $display("%0t: saturated expected %0b got %0b", $time, head.sat, m_tuser);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SAMPLE_SIZE: n_samples = cfg_data;
                    REG_BINARY_MODE: bin_mode = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                term = site_share(s_tdata[NUM_CNT*CNT_W-1:0],
                                  s_tdata[NUM_CNT*CNT_W +: CNT_W], s_tuser);
                if (term > SUM_MAX - run_sum)
                begin
                    run_sum = SUM_MAX;
                    run_sat = 1'b1;
                end
                else
                begin
                    run_sum += term;
                    if (run_sum == SUM_MAX)
                        run_sat = 1'b1;
                end
                if (s_tlast)
                begin
                    nxt.total = run_sum[SUM_W-1:0];
                    nxt.sat = run_sat;
                    due_totals.push_back(nxt);
                    run_sum = 0;
                    run_sat = 1'b0;
                end
            end
            pending <= due_totals.size();
            errors <= err_cnt;
        end
    end

endmodule

// File: sim/tb.sv
// testbench top for the nucleotide diversity accumulator: stimulus, flow control and verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import nda_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_SITES = 1150;
    localparam int ONE_POS      = 5 * CNT_W;

    typedef struct packed {
        logic [CNT_W-1:0]         missing;
        logic [NUM_CNT*CNT_W-1:0] counts;   // a, g, c, t, zero, one from the low end
        logic                     gap;
        logic                     last;
    } site_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic                   s_tuser;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   m_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CNT_W-1:0]       cfg_data;
    int                     pending;
    int                     errors;
    logic                   hold_req;
    int unsigned            tx_quiet = 0;
    int unsigned            rx_quiet = 0;
    int unsigned            stuck_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    nucleotide_diversity_accumulator u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    nda_checker u_chk
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pending   (pending),
        .errors    (errors)
    );

    function automatic site_t site(input int unsigned a, input int unsigned g,
                                   input int unsigned c, input int unsigned t,
                                   input int unsigned zero, input int unsigned one,
                                   input int unsigned missing, input logic gap,
                                   input logic last);
        site_t st;
        st.counts = {one[CNT_W-1:0], zero[CNT_W-1:0], t[CNT_W-1:0],
                     c[CNT_W-1:0], g[CNT_W-1:0], a[CNT_W-1:0]};
        st.missing = missing[CNT_W-1:0];
        st.gap = gap;
        st.last = last;
        return st;
    endfunction

    // idle cycles before the next transaction, with runs of back-to-back traffic
    task automatic draw_wait(inout int unsigned quiet, output int unsigned cycles);
        if (quiet != 0)
        begin
            quiet--;
            cycles = 0;
        end
        else if ($urandom_range(0, 15) == 0)
        begin
            quiet = $urandom_range(8, 40);
            cycles = 0;
        end
        else
            cycles = $urandom_range(0, 11);
    endtask

    task automatic send_site(input site_t st);
        int unsigned gap_cycles;
        draw_wait(tx_quiet, gap_cycles);
        if (gap_cycles != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap_cycles) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(IN_DATA_W - (NUM_CNT + 1) * CNT_W){1'b0}}, st.missing, st.counts};
        s_tuser <= st.gap;
        s_tlast <= st.last;
        do @(posedge clk); while (!s_tready);
    endtask

    // wait until every total is taken and any site without a total has finished
    task automatic settle;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_mode(input int unsigned n, input logic bin);
        settle();
        write_reg(REG_SAMPLE_SIZE, n[CNT_W-1:0]);
        write_reg(REG_BINARY_MODE, {{(CNT_W-1){1'b0}}, bin});
        cfg_valid <= 1'b0;
    endtask

    // result side
    initial
    begin : rx
        int unsigned stall;
        logic        held;
        held = 1'b0;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_req && !held)
            begin
                held = 1'b1;
                stall = HOLD_CYCLES;
            end
            else
                draw_wait(rx_quiet, stall);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stuck_cycles <= 0;
        else if (stuck_cycles >= STALL_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin : stim
        site_t       st;
        int unsigned sent;
        int unsigned plen;
        int unsigned odds;
        int unsigned n;
        int unsigned k;
        int unsigned j;
        int unsigned left;
        int unsigned take;
        int unsigned pick;
        int unsigned states;
        logic        bin;
        hold_req = 1'b0;
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= 1'b0;
        s_tlast <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_SAMPLE_SIZE;
        cfg_data <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // nucleotide mode, ten samples: each skip rule and a full-weight site
        set_mode(10, 1'b0);
        send_site(site(3, 4, 2, 1, 0, 0, 0, 1'b0, 1'b0));
        send_site(site(3, 4, 2, 1, 0, 0, 0, 1'b1, 1'b0));          // gap
        send_site(site(10, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));         // monomorphic
        send_site(site(1, 1, 1, 1, 1, 1, 4, 1'b0, 1'b0));          // six singletons
        send_site(site(5, 5, 0, 0, 0, 0, 11, 1'b0, 1'b0));         // missing above n
        send_site(site(1, 1, 0, 0, 0, 0, 9, 1'b0, 1'b0));          // one usable sample
        send_site(site(8, 8, 0, 0, 0, 0, 0, 1'b0, 1'b0));          // homozygosity too high
        send_site(site(0, 0, 0, 0, 3, 4, 3, 1'b0, 1'b1));
        send_site(site(1023, 1023, 1023, 1023, 1023, 1023, 1023, 1'b0, 1'b1));
        send_site(site(0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b1));

        set_mode(1023, 1'b0);
        send_site(site(512, 511, 0, 0, 0, 0, 0, 1'b0, 1'b0));
        send_site(site(1, 1, 0, 0, 0, 0, 1021, 1'b0, 1'b1));

        // binary mode, nucleotide fields and gap set but ignored
        set_mode(1023, 1'b1);
        send_site(site(1023, 1023, 1023, 1023, 1023, 0, 1023, 1'b1, 1'b0));
        send_site(site(1023, 1023, 1023, 1023, 1023, 511, 1023, 1'b1, 1'b0));
        send_site(site(1023, 1023, 1023, 1023, 1023, 1023, 1023, 1'b1, 1'b1));

        set_mode(5, 1'b1);
        send_site(site(0, 0, 0, 0, 0, 7, 0, 1'b0, 1'b0));          // ones above n
        send_site(site(0, 0, 0, 0, 0, 2, 0, 1'b0, 1'b0));
        send_site(site(0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b1));

        set_mode(1, 1'b1);
        send_site(site(0, 0, 0, 0, 0, 1, 0, 1'b0, 1'b1));          // sample too small

        sent = 0;
        while (sent < RANDOM_SITES)
        begin
            if (sent == 0)
            begin
                // frequent totals while the result side holds off, so the input backs up
                n = $urandom_range(20, 200);
                bin = 1'b0;
                odds = 2;
                plen = 60;
                hold_req = 1'b1;
            end
            else
            begin
                case ($urandom_range(0, 7))
                    0: n = $urandom_range(0, 3);
                    1: n = 1023;
                    2, 3: n = $urandom_range(4, 40);
                    default: n = $urandom_range(2, 1023);
                endcase
                bin = ($urandom_range(0, 2) == 0);
                case ($urandom_range(0, 3))
                    0: odds = 2;
                    1: odds = 4;
                    2: odds = 8;
                    default: odds = 32;
                endcase
                plen = $urandom_range(20, 80);
            end
            set_mode(n, bin);
            for (k = 1; k <= plen; k++)
            begin
                if ($urandom_range(0, 7) == 0 || bin)
                begin
                    for (j = 0; j < NUM_CNT; j++)
                        st.counts[j*CNT_W +: CNT_W] = CNT_W'($urandom_range(0, 1023));
                    st.missing = CNT_W'($urandom_range(0, 1023));
                    st.gap = 1'($urandom_range(0, 1));
                    if (bin && $urandom_range(0, 9) != 0)
                        st.counts[ONE_POS +: CNT_W] = CNT_W'($urandom_range(0, n));
                end
                else
                begin
                    // deal the usable samples over two to four picks of a state, which may repeat
                    st.missing = CNT_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, n)
                                                                    : $urandom_range(0, n / 8));
                    st.gap = ($urandom_range(0, 15) == 0);
                    st.counts = '0;
                    left = n - st.missing;
                    states = $urandom_range(2, 4);
                    for (j = 0; j < states; j++)
                    begin
                        pick = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 5)
                                                           : $urandom_range(0, 3);
                        take = (j == states - 1) ? left : $urandom_range(0, left);
                        st.counts[pick*CNT_W +: CNT_W] =
                            CNT_W'(st.counts[pick*CNT_W +: CNT_W] + take);
                        left = left - take;
                    end
                end
                st.last = (k == plen) || ($urandom_range(1, odds) == 1);
                send_site(st);
                sent++;
            end
        end

        settle();
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// File: nucleotide_diversity_accumulator.f
src/nda_pkg.sv
src/nda_ctrl.sv
src/nda_datapath.sv
src/nucleotide_diversity_accumulator.sv
src/nda_checker.sv
sim/nda_checker.sv
sim/tb.sv
